@@ rtl/pidpc_pkg.sv @@
// Shared widths, limits, register indexes and pipeline word types of the PID position controller.
package pidpc_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned SUM_W      = 48;
  localparam int unsigned DER_W      = 33;
  localparam int unsigned BAND_W     = 16;
  localparam int unsigned LIMIT_W    = 31;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned KP_PROD_W  = 64;
  localparam int unsigned KD_PROD_W  = 65;
  localparam int unsigned HI_PROD_W  = 48;
  localparam int unsigned LO_PROD_W  = 65;
  localparam int unsigned PD_SUM_W   = 66;
  localparam int unsigned I_SUM_W    = 81;
  localparam int unsigned ACC_W      = 82;

  localparam logic [DATA_W-1:0]  DATA_MAX    = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0]  DATA_MIN    = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic [SUM_W-1:0]   SUM_MAX     = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0]   SUM_MIN     = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic [BAND_W-1:0]  BAND_RESET  = 16'd5;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 31'd12000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE = 3'd0,
    CFG_TARGET = 3'd1,
    CFG_KP     = 3'd2,
    CFG_KI     = 3'd3,
    CFG_KD     = 3'd4,
    CFG_BAND   = 3'd5,
    CFG_LIMIT  = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic [DATA_W-1:0] kp;
    logic [DATA_W-1:0] ki;
    logic [DATA_W-1:0] kd;
  } gain_cfg_t;

  typedef struct packed {
    logic [DATA_W-1:0] err;
    logic [SUM_W-1:0]  isum;
    logic [DER_W-1:0]  deriv;
  } err_word_t;

  typedef struct packed {
    logic [DATA_W-1:0]    err;
    logic [KP_PROD_W-1:0] kp_prod;
    logic [KD_PROD_W-1:0] kd_prod;
    logic [HI_PROD_W-1:0] hi_prod;
    logic [LO_PROD_W-1:0] lo_prod;
  } prod_word_t;

  typedef struct packed {
    logic [DATA_W-1:0]   err;
    logic [PD_SUM_W-1:0] pd_sum;
    logic [I_SUM_W-1:0]  i_sum;
  } part_word_t;

endpackage

@@ rtl/pidpc_error.sv @@
// Error saturation, integral with clear conditions and derivative, with the loop state.
module pidpc_error (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                loop_en,
  input  logic [pidpc_pkg::DATA_W-1:0]        in_meas,
  input  logic [pidpc_pkg::DATA_W-1:0]        target,
  input  logic [pidpc_pkg::BAND_W-1:0]        band,
  input  logic [pidpc_pkg::LIMIT_W-1:0]       limit,
  output logic                                err_valid,
  input  logic                                err_ready,
  output pidpc_pkg::err_word_t                err_word
);

  logic                              e1_v_r;
  logic [pidpc_pkg::DATA_W-1:0]      e1_err_r;
  logic [pidpc_pkg::DATA_W-1:0]      e1_err_nxt;
  logic                              e2_v_r;
  pidpc_pkg::err_word_t              e2_word_r;
  logic [pidpc_pkg::SUM_W-1:0]       error_sum_r;
  logic [pidpc_pkg::SUM_W-1:0]       error_sum_nxt;
  logic [pidpc_pkg::DATA_W-1:0]      last_error_r;

  logic                              rdy1;
  logic                              rdy2;
  logic                              adv2;
  logic [pidpc_pkg::DATA_W:0]        diff;
  logic [pidpc_pkg::SUM_W:0]         sum_wide;
  logic [pidpc_pkg::SUM_W-1:0]       sum_sat;
  logic [pidpc_pkg::DATA_W-1:0]      err_abs;
  logic                              clr_small;
  logic                              clr_large;
  logic [pidpc_pkg::DER_W-1:0]       deriv;

  assign rdy2     = !e2_v_r || err_ready;
  assign rdy1     = !e1_v_r || rdy2;
  assign adv2     = e1_v_r && rdy2;
  assign in_ready = rdy1;

  // A word taken while the loop is disabled is dropped here and leaves no trace.
  always_comb begin
    diff = {target[pidpc_pkg::DATA_W-1], target} - {in_meas[pidpc_pkg::DATA_W-1], in_meas};
    if (diff[pidpc_pkg::DATA_W] != diff[pidpc_pkg::DATA_W-1]) begin
      e1_err_nxt = diff[pidpc_pkg::DATA_W] ? pidpc_pkg::DATA_MIN : pidpc_pkg::DATA_MAX;
    end else begin
      e1_err_nxt = diff[pidpc_pkg::DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_v_r <= 1'b0;
    end else if (rdy1) begin
      e1_v_r <= in_valid && loop_en;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      e1_err_r <= e1_err_nxt;
    end
  end

  always_comb begin
    sum_wide = {error_sum_r[pidpc_pkg::SUM_W-1], error_sum_r}
             + {{(pidpc_pkg::SUM_W-pidpc_pkg::DATA_W+1){e1_err_r[pidpc_pkg::DATA_W-1]}},
                e1_err_r};
    if (sum_wide[pidpc_pkg::SUM_W] != sum_wide[pidpc_pkg::SUM_W-1]) begin
      sum_sat = sum_wide[pidpc_pkg::SUM_W] ? pidpc_pkg::SUM_MIN : pidpc_pkg::SUM_MAX;
    end else begin
      sum_sat = sum_wide[pidpc_pkg::SUM_W-1:0];
    end
    // The most negative error has a magnitude of 2^31, which still fits unsigned.
    err_abs   = e1_err_r[pidpc_pkg::DATA_W-1] ? (~e1_err_r + 1'b1) : e1_err_r;
    clr_small = err_abs < {{(pidpc_pkg::DATA_W-pidpc_pkg::BAND_W){1'b0}}, band};
    clr_large = !e1_err_r[pidpc_pkg::DATA_W-1] && (e1_err_r[pidpc_pkg::LIMIT_W-1:0] > limit);
    error_sum_nxt = (clr_small || clr_large) ? '0 : sum_sat;
    // The derivative takes the error before any clear of the integral.
    deriv = {e1_err_r[pidpc_pkg::DATA_W-1], e1_err_r}
          - {last_error_r[pidpc_pkg::DATA_W-1], last_error_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e2_v_r       <= 1'b0;
      error_sum_r  <= '0;
      last_error_r <= '0;
    end else begin
      if (rdy2) begin
        e2_v_r <= e1_v_r;
      end
      if (adv2) begin
        error_sum_r  <= error_sum_nxt;
        last_error_r <= e1_err_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      e2_word_r.err   <= e1_err_r;
      e2_word_r.isum  <= error_sum_nxt;
      e2_word_r.deriv <= deriv;
    end
  end

  assign err_valid = e2_v_r;
  assign err_word  = e2_word_r;

`ifndef SYNTH
  a_clear_small: assert property (@(posedge clk) disable iff (!rst_n)
    (adv2 && clr_small) |=> (error_sum_r == '0))
    else $error("integral not cleared inside the small error band");

  a_last_error: assert property (@(posedge clk) disable iff (!rst_n)
    adv2 |=> (last_error_r == $past(e1_err_r)))
    else $error("last error does not follow the error just used");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv2 |=> ($stable(error_sum_r) && $stable(last_error_r)))
    else $error("loop state changed without a word advancing");

  a_word_sum: assert property (@(posedge clk) disable iff (!rst_n)
    adv2 |=> (e2_word_r.isum == error_sum_r))
    else $error("integral passed on differs from the stored integral");
`endif

endmodule

@@ rtl/pidpc_mult.sv @@
// Gain products, with the 48-bit integral split into two partial products, and their partial sums.
module pidpc_mult (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pidpc_pkg::gain_cfg_t  gains,
  input  logic                  err_valid,
  output logic                  err_ready,
  input  pidpc_pkg::err_word_t  err_word,
  output logic                  part_valid,
  input  logic                  part_ready,
  output pidpc_pkg::part_word_t part_word
);

  logic                              m_v_r;
  pidpc_pkg::prod_word_t             m_word_r;
  logic                              p_v_r;
  pidpc_pkg::part_word_t             p_word_r;
  logic                              rdy3;
  logic                              rdy4;

  logic signed [pidpc_pkg::KP_PROD_W-1:0] kp_prod;
  logic signed [pidpc_pkg::KD_PROD_W-1:0] kd_prod;
  logic signed [pidpc_pkg::HI_PROD_W-1:0] hi_prod;
  logic signed [pidpc_pkg::LO_PROD_W-1:0] lo_prod;
  logic signed [pidpc_pkg::DATA_W:0]      lo_half;
  logic signed [pidpc_pkg::PD_SUM_W-1:0]  kp_ext;
  logic signed [pidpc_pkg::PD_SUM_W-1:0]  kd_ext;
  logic signed [pidpc_pkg::I_SUM_W-1:0]   hi_shift;
  logic signed [pidpc_pkg::I_SUM_W-1:0]   lo_ext;

  assign rdy4      = !p_v_r || part_ready;
  assign rdy3      = !m_v_r || rdy4;
  assign err_ready = rdy3;

  // Integral times gain = (upper 16 bits, signed) * ki * 2^32 + (lower 32 bits, unsigned) * ki.
  assign lo_half = $signed({1'b0, err_word.isum[pidpc_pkg::DATA_W-1:0]});
  assign kp_prod = $signed(err_word.err) * $signed(gains.kp);
  assign kd_prod = $signed(err_word.deriv) * $signed(gains.kd);
  assign hi_prod = $signed(err_word.isum[pidpc_pkg::SUM_W-1:pidpc_pkg::DATA_W])
                 * $signed(gains.ki);
  assign lo_prod = lo_half * $signed(gains.ki);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
      p_v_r <= 1'b0;
    end else begin
      if (rdy3) begin
        m_v_r <= err_valid;
      end
      if (rdy4) begin
        p_v_r <= m_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      m_word_r.err     <= err_word.err;
      m_word_r.kp_prod <= kp_prod;
      m_word_r.kd_prod <= kd_prod;
      m_word_r.hi_prod <= hi_prod;
      m_word_r.lo_prod <= lo_prod;
    end
  end

  assign kp_ext   = {{(pidpc_pkg::PD_SUM_W-pidpc_pkg::KP_PROD_W)
                      {m_word_r.kp_prod[pidpc_pkg::KP_PROD_W-1]}}, m_word_r.kp_prod};
  assign kd_ext   = {{(pidpc_pkg::PD_SUM_W-pidpc_pkg::KD_PROD_W)
                      {m_word_r.kd_prod[pidpc_pkg::KD_PROD_W-1]}}, m_word_r.kd_prod};
  assign hi_shift = {m_word_r.hi_prod[pidpc_pkg::HI_PROD_W-1], m_word_r.hi_prod,
                     {pidpc_pkg::DATA_W{1'b0}}};
  assign lo_ext   = {{(pidpc_pkg::I_SUM_W-pidpc_pkg::LO_PROD_W)
                      {m_word_r.lo_prod[pidpc_pkg::LO_PROD_W-1]}}, m_word_r.lo_prod};

  always_ff @(posedge clk) begin
    if (rdy4) begin
      p_word_r.err    <= m_word_r.err;
      p_word_r.pd_sum <= kp_ext + kd_ext;
      p_word_r.i_sum  <= hi_shift + lo_ext;
    end
  end

  assign part_valid = p_v_r;
  assign part_word  = p_word_r;

endmodule

@@ rtl/pidpc_drive.sv @@
// Final drive sum, Q16.16 scaling and saturation into the result register.
module pidpc_drive (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          part_valid,
  output logic                          part_ready,
  input  pidpc_pkg::part_word_t         part_word,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pidpc_pkg::DATA_W-1:0]  out_drive,
  output logic [pidpc_pkg::DATA_W-1:0]  out_error
);

  localparam int unsigned TOP_W = pidpc_pkg::ACC_W - pidpc_pkg::FRAC_BITS - pidpc_pkg::DATA_W + 1;

  logic                          o_v_r;
  logic [pidpc_pkg::DATA_W-1:0]  drive_r;
  logic [pidpc_pkg::DATA_W-1:0]  drive_nxt;
  logic [pidpc_pkg::DATA_W-1:0]  error_r;
  logic [pidpc_pkg::ACC_W-1:0]   acc;
  logic [TOP_W-1:0]              acc_top;

  assign part_ready = !o_v_r || out_ready;

  // The exact sum is shifted right arithmetically, so it rounds towards minus infinity.
  always_comb begin
    acc = {{(pidpc_pkg::ACC_W-pidpc_pkg::PD_SUM_W){part_word.pd_sum[pidpc_pkg::PD_SUM_W-1]}},
           part_word.pd_sum}
        + {{(pidpc_pkg::ACC_W-pidpc_pkg::I_SUM_W){part_word.i_sum[pidpc_pkg::I_SUM_W-1]}},
           part_word.i_sum};
    acc_top = acc[pidpc_pkg::ACC_W-1:pidpc_pkg::FRAC_BITS+pidpc_pkg::DATA_W-1];
    if ((acc_top == '0) || (acc_top == '1)) begin
      drive_nxt = acc[pidpc_pkg::FRAC_BITS+pidpc_pkg::DATA_W-1:pidpc_pkg::FRAC_BITS];
    end else begin
      drive_nxt = acc[pidpc_pkg::ACC_W-1] ? pidpc_pkg::DATA_MIN : pidpc_pkg::DATA_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (part_ready) begin
      o_v_r <= part_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (part_ready && part_valid) begin
      drive_r <= drive_nxt;
      error_r <= part_word.err;
    end
  end

  assign out_valid = o_v_r;
  assign out_drive = drive_r;
  assign out_error = error_r;

endmodule

@@ rtl/pid_position_controller_top.sv @@
// Top level of the PID position controller: configuration registers and the five-stage pipeline.
//
// One measured position word enters per clock cycle while the result port is not stalled, and
// its drive and error word reaches the result port through the five registered stages; the rate
// is one word per cycle, set by the integral and last error updates in the error stage, the only
// loops carried from word to word. The stages are
// error saturation, integral and derivative update, gain products (integral product split into
// partial products of its top 16 and low 32 bits), partial sums, and final sum with saturation.
// Each stage holds its word when the next one is full, so a stalled result does not stop earlier
// stages from filling. Words taken while enable is clear give no result and leave the integral and
// last error untouched. Configuration is to be written only while the pipeline is empty.
module pid_position_controller_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [31:0]                in_measured_position,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [31:0]                out_drive_value,
  output logic signed [31:0]                out_error_value,
  input  logic                              cfg_wr_en,
  input  logic [pidpc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pidpc_pkg::DATA_W-1:0]      cfg_wr_data
);

  logic                            enable_r;
  logic [pidpc_pkg::DATA_W-1:0]    target_r;
  pidpc_pkg::gain_cfg_t            gains_r;
  logic [pidpc_pkg::BAND_W-1:0]    band_r;
  logic [pidpc_pkg::LIMIT_W-1:0]   limit_r;

  logic                            err_valid;
  logic                            err_ready;
  pidpc_pkg::err_word_t            err_word;
  logic                            part_valid;
  logic                            part_ready;
  pidpc_pkg::part_word_t           part_word;
  logic [pidpc_pkg::DATA_W-1:0]    drive_bits;
  logic [pidpc_pkg::DATA_W-1:0]    error_bits;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r   <= 1'b0;
      target_r   <= '0;
      gains_r    <= '0;
      band_r     <= pidpc_pkg::BAND_RESET;
      limit_r    <= pidpc_pkg::LIMIT_RESET;
    end else if (cfg_wr_en) begin
      case (pidpc_pkg::cfg_idx_t'(cfg_index))
        pidpc_pkg::CFG_ENABLE: enable_r   <= cfg_wr_data[0];
        pidpc_pkg::CFG_TARGET: target_r   <= cfg_wr_data;
        pidpc_pkg::CFG_KP:     gains_r.kp <= cfg_wr_data;
        pidpc_pkg::CFG_KI:     gains_r.ki <= cfg_wr_data;
        pidpc_pkg::CFG_KD:     gains_r.kd <= cfg_wr_data;
        pidpc_pkg::CFG_BAND:   band_r     <= cfg_wr_data[pidpc_pkg::BAND_W-1:0];
        pidpc_pkg::CFG_LIMIT:  limit_r    <= cfg_wr_data[pidpc_pkg::LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  pidpc_error u_error (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .loop_en   (enable_r),
    .in_meas   (in_measured_position),
    .target    (target_r),
    .band      (band_r),
    .limit     (limit_r),
    .err_valid (err_valid),
    .err_ready (err_ready),
    .err_word  (err_word)
  );

  pidpc_mult u_mult (
    .clk        (clk),
    .rst_n      (rst_n),
    .gains      (gains_r),
    .err_valid  (err_valid),
    .err_ready  (err_ready),
    .err_word   (err_word),
    .part_valid (part_valid),
    .part_ready (part_ready),
    .part_word  (part_word)
  );

  pidpc_drive u_drive (
    .clk        (clk),
    .rst_n      (rst_n),
    .part_valid (part_valid),
    .part_ready (part_ready),
    .part_word  (part_word),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_drive  (drive_bits),
    .out_error  (error_bits)
  );

  assign out_drive_value = $signed(drive_bits);
  assign out_error_value = $signed(error_bits);

endmodule
